[sv/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes of the windowed stability detector.
// ----------------------------------------------------------------------------
`default_nettype none
package wsd_pkg;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_ARM    = 2'd2;
  localparam logic [1:0] KIND_LOAD   = 2'd3;

  localparam logic [1:0] ST_INIT     = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_UNSTABLE = 2'd2;
  localparam logic [1:0] ST_STABLE   = 2'd3;

  localparam logic [2:0] REG_RANGE   = 3'd0;
  localparam logic [2:0] REG_MINSAMP = 3'd1;
  localparam logic [2:0] REG_WINDOW  = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_TOL     = 3'd4;
  localparam logic [2:0] REG_TCOUNT  = 3'd5;

  typedef enum logic [3:0] {
    FSM_IDLE  = 4'b0001,
    FSM_SCAN  = 4'b0010,
    FSM_JUDGE = 4'b0100,
    FSM_FIN   = 4'b1000
  } fsm_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage
`default_nettype wire

[sv/windowed_stability_detector_top.sv]
// ----------------------------------------------------------------------------
// windowed_stability_detector_top
// Sliding time window of samples with min/max range judgement and collection.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser carries the kind (sample, tick, arm, load target),
// tdata the sample and target fields. Every input transaction yields exactly
// one output transaction on m_*, carrying the stability state and flags.
// Configuration registers are written through cfg_we/cfg_index/cfg_data.
// Samples live in a row of WINDOW_DEPTH cells, newest first. A sample shifts
// into the row, then the row rotates once around past a scan unit at its
// tail that evicts old samples and finds min and max; a judge step then sets
// the state and a final step delivers the result once the output register
// can take it. Other kinds skip the rotation and go straight to delivery.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted and worked on, and the block only
// holds when a second result is ready before the first was taken.
// Reset is synchronous: empty window, state init, defaults in all configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none
module windowed_stability_detector_top
  import wsd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 256,
  parameter int TARGETS      = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // sample_value, sample_time, target_index, target_value, zero pad
  input  wire logic [103:0] s_tdata,
  // kind
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // stability, state_changed, became_stable, collect_hits, window_overflow, pad
  output logic [15:0]       m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  logic [30:0] stability_range;
  logic [8:0]  min_samples;
  logic [31:0] window_ms;
  logic [19:0] timeout_ms;
  logic [30:0] collect_tolerance;
  logic [3:0]  target_count;

  fsm_t               fsm;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   step_cnt;
  logic [31:0]        newest_time;
  logic signed [31:0] newest_value;
  logic [1:0]         cur_state;
  logic [1:0]         rep_state;
  logic               armed;
  logic [19:0]        idle_ticks;
  logic [19:0]        idle_ticks_next;
  logic               emit;
  logic               is_sample;
  logic               overflow;

  logic               accept;
  logic               fin_go;
  logic               collect_en;
  logic [3:0]         hits;
  logic               changed;
  scan_ctl_t          ctl;
  logic [CNT_W-1:0]   kept;
  logic signed [31:0] wmin;
  logic signed [31:0] wmax;
  logic [63:0]        cell_q [WINDOW_DEPTH];
  logic [63:0]        cell0_d;
  logic               cell_en;

  assign s_tready   = (fsm == FSM_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign fin_go     = (fsm == FSM_FIN) && (!m_tvalid || m_tready);
  assign collect_en = fin_go && is_sample && armed && (cur_state == ST_STABLE);
  assign changed    = emit && (cur_state != rep_state);
  assign idle_ticks_next = idle_ticks + 20'd1;

  // cell row
  assign cell_en = (accept && (s_tuser == KIND_SAMPLE)) || (fsm == FSM_SCAN);
  assign cell0_d = (fsm == FSM_SCAN) ? cell_q[WINDOW_DEPTH-1] : s_tdata[63:0];

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      wsd_cell u_cell (.clk(clk), .en(cell_en), .din(cell0_d), .dout(cell_q[g]));
    end else begin : g_body
      wsd_cell u_cell (.clk(clk), .en(cell_en), .din(cell_q[g-1]), .dout(cell_q[g]));
    end
  end

  assign ctl.clear = accept;
  assign ctl.step  = (fsm == FSM_SCAN);

  wsd_scan #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_scan (
    .clk(clk), .ctl(ctl), .idx(IDX_W'(WINDOW_DEPTH - 1) - step_cnt), .count(count),
    .tap(cell_q[WINDOW_DEPTH-1]), .newest_time(newest_time), .window_ms(window_ms),
    .kept(kept), .wmin(wmin), .wmax(wmax)
  );

  wsd_targets #(.TARGETS(TARGETS)) u_targets (
    .clk(clk), .rst(rst), .load(accept && (s_tuser == KIND_LOAD)),
    .load_index(s_tdata[66:64]), .load_value(signed'(s_tdata[98:67])),
    .collect(collect_en), .sample(newest_value), .tolerance(collect_tolerance),
    .target_count(target_count), .hits(hits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stability_range   <= 31'd65536;
      min_samples       <= 9'd10;
      window_ms         <= 32'd10000;
      timeout_ms        <= 20'd5000;
      collect_tolerance <= 31'd6554;
      target_count      <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE:   stability_range   <= cfg_data[30:0];
        REG_MINSAMP: min_samples       <= cfg_data[8:0];
        REG_WINDOW:  window_ms         <= cfg_data;
        REG_TIMEOUT: timeout_ms        <= cfg_data[19:0];
        REG_TOL:     collect_tolerance <= cfg_data[30:0];
        REG_TCOUNT:  target_count      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      newest_value <= signed'(s_tdata[31:0]);
      newest_time  <= s_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= FSM_IDLE;
      count      <= '0;
      step_cnt   <= '0;
      cur_state  <= ST_INIT;
      rep_state  <= ST_INIT;
      armed      <= 1'b0;
      idle_ticks <= '0;
      emit       <= 1'b0;
      is_sample  <= 1'b0;
      overflow   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (fsm)
        FSM_IDLE: begin
          if (accept) begin
            is_sample <= (s_tuser == KIND_SAMPLE);
            emit      <= 1'b0;
            overflow  <= 1'b0;
            fsm       <= FSM_FIN;
            case (s_tuser)
              KIND_SAMPLE: begin
                idle_ticks <= '0;
                emit       <= 1'b1;
                step_cnt   <= '0;
                fsm        <= FSM_SCAN;
                if (count >= CNT_W'(WINDOW_DEPTH)) begin
                  overflow <= 1'b1;
                  count    <= CNT_W'(WINDOW_DEPTH);
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              KIND_TICK: begin
                if (idle_ticks_next >= timeout_ms) begin
                  idle_ticks <= '0;
                  cur_state  <= ST_TIMEOUT;
                  emit       <= 1'b1;
                end else begin
                  idle_ticks <= idle_ticks_next;
                end
              end
              KIND_ARM:  armed <= 1'b1;
              KIND_LOAD: ;
              default: ;
            endcase
          end
        end
        FSM_SCAN: begin
          step_cnt <= step_cnt + IDX_W'(1);
          if (step_cnt == IDX_W'(WINDOW_DEPTH - 1)) fsm <= FSM_JUDGE;
        end
        FSM_JUDGE: begin
          count <= kept;
          if ({{(32-CNT_W){1'b0}}, kept} < {23'd0, min_samples}) begin
            cur_state <= ST_INIT;
          end else if (33'(wmax) - 33'(wmin) > 33'({2'b00, stability_range})) begin
            cur_state <= ST_UNSTABLE;
          end else begin
            cur_state <= ST_STABLE;
          end
          fsm <= FSM_FIN;
        end
        FSM_FIN: begin
          if (fin_go) begin
            if (collect_en) armed <= 1'b0;
            if (emit) rep_state <= cur_state;
            m_tvalid <= 1'b1;
            fsm      <= FSM_IDLE;
          end
        end
        default: fsm <= FSM_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      m_tdata <= {7'd0, overflow, (collect_en ? hits : 4'd0),
                  changed && (cur_state == ST_STABLE), changed, cur_state};
    end
  end
endmodule
`default_nettype wire

[sv/wsd_cell.sv]
// ----------------------------------------------------------------------------
// wsd_cell
// One window cell: holds a sample value and timestamp, loads from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module wsd_cell (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] din,
  output logic      [63:0] dout
);
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= din;
    end
  end
endmodule
`default_nettype wire

[sv/wsd_scan.sv]
// ----------------------------------------------------------------------------
// wsd_scan
// Scan unit at the chain tail: eviction of old samples and window min/max.
// ----------------------------------------------------------------------------
`default_nettype none
module wsd_scan
  import wsd_pkg::*;
#(
  parameter int IDX_W = 8,
  parameter int CNT_W = 9
) (
  input  wire logic               clk,
  input  wire scan_ctl_t          ctl,
  input  wire logic [IDX_W-1:0]   idx,
  input  wire logic [CNT_W-1:0]   count,
  input  wire logic [63:0]        tap,
  input  wire logic [31:0]        newest_time,
  input  wire logic [31:0]        window_ms,
  output logic      [CNT_W-1:0]   kept,
  output logic signed [31:0]      wmin,
  output logic signed [31:0]      wmax
);
  logic               evicting;
  logic               in_win;
  logic               old;
  logic signed [31:0] v;

  assign v      = signed'(tap[31:0]);
  assign in_win = CNT_W'(idx) < count;
  assign old    = ({1'b0, tap[63:32]} + {1'b0, window_ms}) < {1'b0, newest_time};

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      evicting <= 1'b1;
      kept     <= '0;
    end else if (ctl.step && in_win) begin
      if (evicting && (idx != '0) && old) begin
        kept <= CNT_W'(idx);
      end else begin
        evicting <= 1'b0;
        if (evicting) begin
          kept <= CNT_W'(idx) + CNT_W'(1);
          wmin <= v;
          wmax <= v;
        end else begin
          if (v < wmin) wmin <= v;
          if (v > wmax) wmax <= v;
        end
      end
    end
  end
endmodule
`default_nettype wire

[sv/wsd_targets.sv]
// ----------------------------------------------------------------------------
// wsd_targets
// Target table with collected flags and the tolerance match.
// ----------------------------------------------------------------------------
`default_nettype none
module wsd_targets #(
  parameter int TARGETS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire logic [2:0]         load_index,
  input  wire logic signed [31:0] load_value,
  input  wire logic               collect,
  input  wire logic signed [31:0] sample,
  input  wire logic [30:0]        tolerance,
  input  wire logic [3:0]         target_count,
  output logic      [3:0]         hits
);
  localparam int HW = $clog2(TARGETS + 1);

  logic signed [31:0] tval [TARGETS];
  logic [TARGETS-1:0] done;
  logic [TARGETS-1:0] match;
  logic [HW-1:0]      nhit;

  always_comb begin
    nhit = '0;
    for (int i = 0; i < TARGETS; i++) begin
      match[i] = collect && !done[i] && (32'(i) < {28'd0, target_count})
        && (34'(tval[i]) - signed'(34'({1'b0, tolerance})) < 34'(sample))
        && (34'(tval[i]) + signed'(34'({1'b0, tolerance})) > 34'(sample));
      nhit = nhit + HW'(match[i]);
    end
  end

  assign hits = 4'(nhit);

  always_ff @(posedge clk) begin
    if (load && (32'(load_index) < 32'(TARGETS))) begin
      tval[load_index] <= load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else begin
      for (int i = 0; i < TARGETS; i++) begin
        if (load && (32'(load_index) == 32'(i))) done[i] <= 1'b0;
        else if (match[i]) done[i] <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[sv/wsd_checker.sv]
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the windowed stability detector, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
module wsd_checker
  import wsd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in work");

  a_became: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[3] || (m_tdata[2] && (m_tdata[1:0] == ST_STABLE)))
    else $error("became_stable without change into stable");

  a_hits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:4] == 4'd0) || (m_tdata[1:0] == ST_STABLE))
    else $error("collect hits outside stable state");
endmodule

bind windowed_stability_detector_top wsd_checker u_wsd_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
